/* hdl/free_range_allocator_core_macros.svh */
// Assertion macros shared by the free range allocator RTL.
`ifndef FREE_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define FREE_RANGE_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRA_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`else
`define FRA_ASSERT(lbl, prop, msg)
`define FRA_ASSERT_CLK(lbl, ck, rn, prop, msg)
`endif
`endif

/* hdl/fra_pkg.sv */
// Types, codes and defaults shared by the free range allocator.
`timescale 1ns / 1ps
`default_nettype none
package fra_pkg;
  localparam int FW = 40;
  localparam int DEF_ENTRIES = 64;
  localparam int DEF_FRAME_BITS = 40;
  localparam int DEF_PAGE_SIZE = 4096;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_PAGES = 2'd1;
  localparam logic [1:0] MODE_AT    = 2'd2;
  localparam logic [1:0] MODE_ACQ   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_OVERLAP  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;

  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_RSV   = 2'd1;
  localparam logic [1:0] KIND_SPLIT = 2'd2;

  typedef struct packed {
    logic [FW-1:0] start;
    logic [FW-1:0] len;
    logic          rsv;
  } entry_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [FW-1:0] pages;
    logic [FW-1:0] start;
  } res_t;
endpackage
`default_nettype wire

/* hdl/fra_table.sv */
// Range table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fra_table #(
  parameter int ENTRIES = fra_pkg::DEF_ENTRIES,
  parameter int AW = $clog2(ENTRIES)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire fra_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output fra_pkg::entry_t      rdata
);
  import fra_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/free_range_allocator_core.sv */
// Top level of the free range allocator: sequencer around the range table.
// Usage:
//   in_*  : one beat is one request. tuser holds mode and range kind, tdata
//           the start frame and page count.
//   out_* : result beats. tdata holds start and page count, tuser kind and
//           status; tlast marks the final beat of a request.
//   cfg_* : write of the low reserve limit, taken only while idle.
// A request is taken only when idle. It scans the sorted table entry by
// entry (read, then evaluate) and moves entries one at a time (read, then
// write) when a range is inserted or removed, all through the table's one
// read port and one write port. Allocate pages passes through a push step
// for each range handed out and shifts the table down once for each whole
// range taken.
// A finished beat waits in the output register; a stalled receiver holds the
// sequencer only when a further beat must be placed.
// Reset empties the table at once and loads the limit with 1 MB in frames.
`timescale 1ns / 1ps
`default_nettype none
`include "free_range_allocator_core_macros.svh"
module free_range_allocator_core #(
  parameter int ENTRIES    = fra_pkg::DEF_ENTRIES,
  parameter int FRAME_BITS = fra_pkg::DEF_FRAME_BITS,
  parameter int PAGE_SIZE  = fra_pkg::DEF_PAGE_SIZE
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [2*fra_pkg::FW-1:0] in_tdata,  // start_frame, page_count
  input  wire logic [2:0]            in_tuser,     // mode, range_kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2*fra_pkg::FW-1:0]   out_tdata,    // out_start, out_pages
  output logic [4:0]                 out_tuser,    // out_kind, status
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [fra_pkg::FW-1:0] cfg_data
);
  import fra_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [FW:0] SPACE_TOP = (FRAME_BITS >= FW) ? {1'b0, {FW{1'b1}}}
                                    : ((FW+1)'(1) << FRAME_BITS) - (FW+1)'(1);
  localparam logic [FW-1:0] LIMIT_RST = FW'(1048576 / PAGE_SIZE);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EV    = 4'd3;
  localparam logic [3:0] S_END   = 4'd4;
  localparam logic [3:0] S_PUSH  = 4'd5;
  localparam logic [3:0] S_DN_RD = 4'd6;
  localparam logic [3:0] S_DN_WR = 4'd7;
  localparam logic [3:0] S_UP_RD = 4'd8;
  localparam logic [3:0] S_UP_WR = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [FW-1:0] s_r, s_nxt, c_r, c_nxt, done_r, done_nxt, lim_r;
  logic kind_r, kind_nxt;
  logic [FW:0] e_r, e_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, shj_r, shj_nxt, shp_r, shp_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic pos_found_r, pos_found_nxt, has_prev_r, has_prev_nxt;
  logic rm_r, rm_nxt, pend_v_r, pend_v_nxt;
  entry_t ins_r, ins_nxt, next_r, next_nxt, prev_r, prev_nxt;
  res_t item_r, item_nxt, pend_r, pend_nxt, out_r, out_nxt;
  logic [2:0] fin_r, fin_nxt, ost_r, ost_nxt;
  logic olast_r, olast_nxt, ovalid_r, ovalid_nxt;

  logic mem_we;
  logic [CW-1:0] waddr, raddr;
  entry_t wdata, rd_q;

  logic [FW-1:0] cs, left, p1, p2;
  logic [FW:0] ce, prev_end, diff2;
  logic kf, out_free, ptouch, ntouch;

  fra_table #(.ENTRIES(ENTRIES), .AW(AW)) u_table (
    .clk(clk), .we(mem_we), .waddr(waddr[AW-1:0]), .wdata(wdata),
    .raddr(raddr[AW-1:0]), .rdata(rd_q)
  );

  assign cs = rd_q.start;
  assign ce = {1'b0, rd_q.start} + {1'b0, rd_q.len};
  assign left = c_r - done_r;
  assign p1 = s_r - cs;
  assign diff2 = ce - e_r;
  assign p2 = diff2[FW-1:0];
  assign kf = (e_r < {1'b0, lim_r}) ? 1'b1 : kind_r;
  assign out_free = !ovalid_r || out_tready;
  assign prev_end = {1'b0, prev_r.start} + {1'b0, prev_r.len};
  assign ptouch = has_prev_r && (prev_end == {1'b0, s_r});
  assign ntouch = pos_found_r && ({1'b0, next_r.start} == e_r);

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = {out_r.pages, out_r.start};
  assign out_tuser = {ost_r, out_r.kind};
  assign out_tlast = olast_r;

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; mode_nxt = mode_r;
    s_nxt = s_r; c_nxt = c_r; done_nxt = done_r; kind_nxt = kind_r; e_nxt = e_r;
    cnt_nxt = cnt_r; idx_nxt = idx_r; shj_nxt = shj_r; shp_nxt = shp_r;
    pos_nxt = pos_r; pos_found_nxt = pos_found_r; has_prev_nxt = has_prev_r;
    rm_nxt = rm_r; pend_v_nxt = pend_v_r; ins_nxt = ins_r; next_nxt = next_r;
    prev_nxt = prev_r; item_nxt = item_r; pend_nxt = pend_r; out_nxt = out_r;
    fin_nxt = fin_r; ost_nxt = ost_r; olast_nxt = olast_r;
    ovalid_nxt = ovalid_r && !out_tready;
    mem_we = 1'b0; waddr = idx_r; wdata = ins_r; raddr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tuser[1:0];
          kind_nxt = in_tuser[2];
          s_nxt = in_tdata[FW-1:0];
          c_nxt = in_tdata[2*FW-1:FW];
          e_nxt = {1'b0, in_tdata[FW-1:0]} + {1'b0, in_tdata[2*FW-1:FW]};
          idx_nxt = '0; done_nxt = '0; pend_v_nxt = 1'b0;
          pos_found_nxt = 1'b0; has_prev_nxt = 1'b0; pos_nxt = cnt_r;
          fin_nxt = ST_OK;
          state_nxt = S_START;
        end
      end
      S_START: begin
        pend_nxt = '0;
        state_nxt = S_RD;
        unique case (mode_r)
          MODE_ADD: begin
            kind_nxt = kf;
            pend_nxt = '{kind: {1'b0, kf}, pages: c_r, start: s_r};
            if (c_r == '0) begin
              fin_nxt = ST_EMPTY; state_nxt = S_FIN;
            end else if (e_r > SPACE_TOP) begin
              fin_nxt = ST_OVERLAP; state_nxt = S_FIN;
            end
          end
          MODE_PAGES: begin
            if (c_r == '0) state_nxt = S_FIN;
          end
          MODE_AT: begin
            if (c_r == '0) begin
              fin_nxt = ST_EMPTY; state_nxt = S_FIN;
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        if (idx_r >= cnt_r || (mode_r == MODE_PAGES && done_r >= c_r)) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_RD;
        unique case (mode_r)
          MODE_ADD: begin
            if ({1'b0, s_r} < ce && {1'b0, cs} < e_r) begin
              fin_nxt = ST_OVERLAP; state_nxt = S_FIN;
            end else if (cs > s_r) begin
              if (!pos_found_r) begin
                pos_nxt = idx_r; pos_found_nxt = 1'b1; next_nxt = rd_q;
              end
            end else begin
              prev_nxt = rd_q; has_prev_nxt = 1'b1;
            end
          end
          MODE_PAGES: begin
            if (!rd_q.rsv) begin
              idx_nxt = idx_r;
              state_nxt = S_PUSH;
              if (left >= rd_q.len) begin
                item_nxt = '{kind: KIND_FREE, pages: rd_q.len, start: cs};
                done_nxt = done_r + rd_q.len;
                rm_nxt = 1'b1;
              end else begin
                mem_we = 1'b1;
                wdata = '{start: cs + left, len: rd_q.len - left, rsv: 1'b0};
                item_nxt = '{kind: KIND_SPLIT, pages: left, start: cs};
                done_nxt = c_r;
                rm_nxt = 1'b0;
              end
            end
          end
          MODE_AT: begin
            if (s_r >= cs && ce >= e_r) begin
              idx_nxt = idx_r;
              pend_nxt = '{kind: {1'b0, rd_q.rsv}, pages: c_r, start: s_r};
              state_nxt = S_FIN;
              if (p1 == '0 && p2 != '0) begin
                mem_we = 1'b1;
                wdata = '{start: e_r[FW-1:0], len: p2, rsv: rd_q.rsv};
              end else if (p1 != '0 && p2 == '0) begin
                mem_we = 1'b1;
                wdata = '{start: cs, len: p1, rsv: rd_q.rsv};
              end else if (p1 != '0) begin
                if (cnt_r >= FULL_CNT) begin
                  pend_nxt = '0; fin_nxt = ST_FULL;
                end else begin
                  mem_we = 1'b1;
                  wdata = '{start: cs, len: p1, rsv: rd_q.rsv};
                  ins_nxt = '{start: e_r[FW-1:0], len: p2, rsv: rd_q.rsv};
                  shj_nxt = cnt_r; shp_nxt = idx_r + CW'(1);
                  ret_nxt = S_FIN; state_nxt = S_UP_RD;
                end
              end else begin
                shj_nxt = idx_r; ret_nxt = S_FIN; state_nxt = S_DN_RD;
              end
            end
          end
          default: begin
            if (rd_q.rsv == kind_r && s_r >= cs && {1'b0, s_r} < ce) begin
              pend_nxt = '{kind: {1'b0, rd_q.rsv}, pages: rd_q.len, start: cs};
              shj_nxt = idx_r; ret_nxt = S_FIN; state_nxt = S_DN_RD;
            end
          end
        endcase
      end
      S_PUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_nxt = pend_r; ost_nxt = ST_OK; olast_nxt = 1'b0; ovalid_nxt = 1'b1;
          end
          pend_nxt = item_r;
          pend_v_nxt = 1'b1;
          if (rm_r) begin
            shj_nxt = idx_r; ret_nxt = S_RD; state_nxt = S_DN_RD;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_END: begin
        state_nxt = S_FIN;
        unique case (mode_r)
          MODE_ADD: begin
            if (ptouch) begin
              mem_we = 1'b1;
              waddr = pos_r - CW'(1);
              wdata = '{start: prev_r.start,
                        len: prev_r.len + c_r + (ntouch ? next_r.len : '0),
                        rsv: prev_r.rsv};
              if (ntouch) begin
                shj_nxt = pos_r; ret_nxt = S_FIN; state_nxt = S_DN_RD;
              end
            end else if (ntouch) begin
              mem_we = 1'b1;
              waddr = pos_r;
              wdata = '{start: s_r, len: next_r.len + c_r, rsv: next_r.rsv};
            end else if (cnt_r >= FULL_CNT) begin
              fin_nxt = ST_FULL;
            end else begin
              ins_nxt = '{start: s_r, len: c_r, rsv: kind_r};
              shj_nxt = cnt_r; shp_nxt = pos_r; ret_nxt = S_FIN; state_nxt = S_UP_RD;
            end
          end
          MODE_PAGES: begin
            fin_nxt = (pend_v_r && done_r == c_r) ? ST_OK : ST_SHORT;
          end
          default: begin
            fin_nxt = ST_NOTFOUND;
          end
        endcase
      end
      S_DN_RD: begin
        raddr = shj_r + CW'(1);
        if (shj_r + CW'(1) < cnt_r) begin
          state_nxt = S_DN_WR;
        end else begin
          cnt_nxt = cnt_r - CW'(1); state_nxt = ret_r;
        end
      end
      S_DN_WR: begin
        mem_we = 1'b1; waddr = shj_r; wdata = rd_q;
        shj_nxt = shj_r + CW'(1); state_nxt = S_DN_RD;
      end
      S_UP_RD: begin
        raddr = shj_r - CW'(1);
        if (shj_r > shp_r) begin
          state_nxt = S_UP_WR;
        end else begin
          mem_we = 1'b1; waddr = shp_r; wdata = ins_r;
          cnt_nxt = cnt_r + CW'(1); state_nxt = ret_r;
        end
      end
      S_UP_WR: begin
        mem_we = 1'b1; waddr = shj_r; wdata = rd_q;
        shj_nxt = shj_r - CW'(1); state_nxt = S_UP_RD;
      end
      S_FIN: begin
        if (out_free) begin
          out_nxt = pend_r; ost_nxt = fin_r; olast_nxt = 1'b1; ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      pend_v_r <= 1'b0;
      lim_r <= LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_valid && cfg_ready) lim_r <= cfg_data;
    end
    ret_r <= ret_nxt; mode_r <= mode_nxt; s_r <= s_nxt; c_r <= c_nxt;
    done_r <= done_nxt; kind_r <= kind_nxt; e_r <= e_nxt; idx_r <= idx_nxt;
    shj_r <= shj_nxt; shp_r <= shp_nxt; pos_r <= pos_nxt;
    pos_found_r <= pos_found_nxt; has_prev_r <= has_prev_nxt; rm_r <= rm_nxt;
    ins_r <= ins_nxt; next_r <= next_nxt; prev_r <= prev_nxt; item_r <= item_nxt;
    pend_r <= pend_nxt; out_r <= out_nxt; fin_r <= fin_nxt; ost_r <= ost_nxt;
    olast_r <= olast_nxt;
  end

  `FRA_ASSERT(a_busy_after_take, (in_tvalid && in_tready) |=> !in_tready, "ready after take")
  `FRA_ASSERT(a_cnt_step, (cnt_r != $past(cnt_r)) |-> ((cnt_r == $past(cnt_r) + CW'(1)) || ($past(cnt_r) == cnt_r + CW'(1))), "count jumped")
  `FRA_ASSERT(a_err_last, (out_tvalid && out_tuser[4:2] != ST_OK) |-> out_tlast, "error beat not last")
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the free range allocator core.
`timescale 1ns / 1ps
`default_nettype none

class alloc_scoreboard;
  typedef struct {
    logic [39:0] start;
    logic [39:0] pages;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic        last;
  } beat_t;

  localparam longint unsigned FRAME_TOP = 64'hFF_FFFF_FFFF;
  localparam int TABLE_DEPTH = 64;

  longint unsigned tab_start[$];
  longint unsigned tab_len[$];
  bit              tab_rsv[$];
  longint unsigned reserve_limit = 256;
  beat_t           pending[$];
  int              errors = 0;

  function void report(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endfunction

  function void push_beat(longint unsigned s, longint unsigned p, logic [1:0] k,
                          logic [2:0] st, logic l);
    beat_t b;
    b.start = s[39:0];
    b.pages = p[39:0];
    b.kind = k;
    b.status = st;
    b.last = l;
    pending.push_back(b);
  endfunction

  function logic [2:0] add_range(longint unsigned s, longint unsigned c, bit k);
    longint unsigned e;
    int n;
    int pos;
    e = s + c;
    n = tab_start.size();
    if (c == 0) return fra_pkg::ST_EMPTY;
    if (e > FRAME_TOP) return fra_pkg::ST_OVERLAP;
    for (int i = 0; i < n; i++)
      if (s < tab_start[i] + tab_len[i] && tab_start[i] < e) return fra_pkg::ST_OVERLAP;
    pos = n;
    for (int i = 0; i < n; i++)
      if (tab_start[i] > s) begin
        pos = i;
        break;
      end
    if (pos > 0 && tab_start[pos-1] + tab_len[pos-1] == s) begin
      tab_len[pos-1] += c;
      if (pos < n && tab_start[pos] == e) begin
        tab_len[pos-1] += tab_len[pos];
        tab_start.delete(pos);
        tab_len.delete(pos);
        tab_rsv.delete(pos);
      end
    end else if (pos < n && tab_start[pos] == e) begin
      tab_start[pos] = s;
      tab_len[pos] += c;
    end else begin
      if (n >= TABLE_DEPTH) return fra_pkg::ST_FULL;
      tab_start.insert(pos, s);
      tab_len.insert(pos, c);
      tab_rsv.insert(pos, k);
    end
    return fra_pkg::ST_OK;
  endfunction

  function void take_pages(longint unsigned want);
    beat_t got_q[$];
    beat_t b;
    longint unsigned done;
    longint unsigned left;
    longint unsigned len;
    longint unsigned s;
    int i;
    done = 0;
    i = 0;
    if (want == 0) begin
      push_beat(0, 0, fra_pkg::KIND_FREE, fra_pkg::ST_OK, 1);
      return;
    end
    while (i < tab_start.size() && done < want) begin
      left = want - done;
      len = tab_len[i];
      s = tab_start[i];
      if (tab_rsv[i]) begin
        i++;
        continue;
      end
      b.status = fra_pkg::ST_OK;
      b.last = 0;
      b.start = s[39:0];
      if (left >= len) begin
        tab_start.delete(i);
        tab_len.delete(i);
        tab_rsv.delete(i);
        b.pages = len[39:0];
        b.kind = fra_pkg::KIND_FREE;
        done += len;
      end else begin
        tab_start[i] = s + left;
        tab_len[i] = len - left;
        b.pages = left[39:0];
        b.kind = fra_pkg::KIND_SPLIT;
        done += left;
      end
      got_q.push_back(b);
    end
    if (got_q.size() == 0) begin
      push_beat(0, 0, fra_pkg::KIND_FREE, fra_pkg::ST_SHORT, 1);
      return;
    end
    got_q[got_q.size()-1].status = (done == want) ? fra_pkg::ST_OK : fra_pkg::ST_SHORT;
    got_q[got_q.size()-1].last = 1;
    foreach (got_q[j]) pending.push_back(got_q[j]);
  endfunction

  function logic [2:0] carve(longint unsigned s, longint unsigned c, output bit k);
    longint unsigned e;
    longint unsigned cs;
    longint unsigned ce;
    longint unsigned p1;
    longint unsigned p2;
    e = s + c;
    k = 0;
    if (c == 0) return fra_pkg::ST_EMPTY;
    for (int i = 0; i < tab_start.size(); i++) begin
      cs = tab_start[i];
      ce = cs + tab_len[i];
      if (s < cs || ce < e) continue;
      p1 = s - cs;
      p2 = ce - e;
      k = tab_rsv[i];
      if (p1 == 0 && p2 != 0) begin
        tab_start[i] = e;
        tab_len[i] = p2;
      end else if (p1 != 0 && p2 == 0) begin
        tab_len[i] = p1;
      end else if (p1 != 0 && p2 != 0) begin
        if (tab_start.size() >= TABLE_DEPTH) return fra_pkg::ST_FULL;
        tab_len[i] = p1;
        tab_start.insert(i + 1, e);
        tab_len.insert(i + 1, p2);
        tab_rsv.insert(i + 1, k);
      end else begin
        tab_start.delete(i);
        tab_len.delete(i);
        tab_rsv.delete(i);
      end
      return fra_pkg::ST_OK;
    end
    return fra_pkg::ST_NOTFOUND;
  endfunction

  function void note_request(logic [1:0] mode, logic [39:0] s, logic [39:0] c, bit k);
    logic [2:0] st;
    bit ck;
    longint unsigned cs;
    longint unsigned len;
    case (mode)
      fra_pkg::MODE_ADD: begin
        if (longint'(s) + longint'(c) < reserve_limit) k = 1;
        st = add_range(s, c, k);
        push_beat(s, c, {1'b0, k}, st, 1);
      end
      fra_pkg::MODE_PAGES: take_pages(c);
      fra_pkg::MODE_AT: begin
        st = carve(s, c, ck);
        if (st == fra_pkg::ST_OK) push_beat(s, c, {1'b0, ck}, st, 1);
        else push_beat(0, 0, fra_pkg::KIND_FREE, st, 1);
      end
      default: begin
        for (int i = 0; i < tab_start.size(); i++) begin
          cs = tab_start[i];
          len = tab_len[i];
          if (tab_rsv[i] != k) continue;
          if (s >= cs && s < cs + len) begin
            tab_start.delete(i);
            tab_len.delete(i);
            tab_rsv.delete(i);
            push_beat(cs, len, {1'b0, k}, fra_pkg::ST_OK, 1);
            return;
          end
        end
        push_beat(0, 0, fra_pkg::KIND_FREE, fra_pkg::ST_NOTFOUND, 1);
      end
    endcase
  endfunction

  function void check_beat(logic [39:0] s, logic [39:0] p, logic [1:0] k,
                           logic [2:0] st, logic l);
    beat_t b;
    if (pending.size() == 0) begin
      report("unexpected beat start", s, 0);
      return;
    end
    b = pending.pop_front();
    if (s !== b.start) report("start", s, b.start);
    if (p !== b.pages) report("pages", p, b.pages);
    if (k !== b.kind) report("kind", k, b.kind);
    if (st !== b.status) report("status", st, b.status);
    if (l !== b.last) report("last", l, b.last);
  endfunction
endclass

module tb_top;
  import fra_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // start_frame, page_count
  logic [2:0]  in_tuser = '0;   // mode, range_kind
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [79:0] out_tdata;       // out_start, out_pages
  logic [4:0]  out_tuser;       // out_kind, status
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [39:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  bit idle_on = 1;
  int stall_left = 0;
  int cycles = 0;

  free_range_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(out_tdata[39:0], out_tdata[79:40], out_tuser[1:0], out_tuser[4:2],
                    out_tlast);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 0;
      stall_left--;
    end else begin
      out_tready = 1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_req(logic [1:0] mode, logic [39:0] s, logic [39:0] c, bit k);
    int g;
    g = pick_gap();
    @(negedge clk);
    if (g > 0) begin
      in_tvalid = 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {c, s};
    in_tuser = {k, mode};
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, s, c, k);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_limit(logic [39:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.reserve_limit = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_req();
    int r;
    int i;
    logic [39:0] s;
    logic [39:0] c;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      c = ($urandom_range(0, 30) == 0) ? 40'd0 : 40'($urandom_range(1, 16));
      send_req(MODE_ADD, 40'($urandom_range(0, 2047)), c, 1'($urandom_range(0, 1)));
    end else if (r < 60) begin
      send_req(MODE_PAGES, 40'd0, 40'($urandom_range(0, 40)), 1'($urandom_range(0, 1)));
    end else if (r < 88 && sb.tab_start.size() > 0) begin
      i = $urandom_range(0, sb.tab_start.size() - 1);
      s = 40'(sb.tab_start[i] + $urandom_range(0, sb.tab_len[i] - 1));
      if (r < 75) begin
        c = 40'($urandom_range(0, sb.tab_start[i] + sb.tab_len[i] - s));
        if ($urandom_range(0, 9) == 0) c = c + 40'd1;
        send_req(MODE_AT, s, c, 1'($urandom_range(0, 1)));
      end else begin
        send_req(MODE_ACQ, s, 40'($urandom_range(0, 7)),
                 ($urandom_range(0, 4) == 0) ? !sb.tab_rsv[i] : sb.tab_rsv[i]);
      end
    end else begin
      send_req(2'($urandom_range(0, 3)), 40'({$urandom, $urandom}),
               40'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) idle_on = $urandom_range(0, 3) != 0;
      random_req();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_req(MODE_ADD, 500, 0, 0);
    send_req(MODE_ADD, 40'hFF_FFFF_FFF0, 32, 1);
    send_req(MODE_ADD, 40'hFF_FFFF_FFF4, 11, 1);
    send_req(MODE_ADD, 100, 50, 0);
    send_req(MODE_ADD, 300, 100, 0);
    send_req(MODE_ADD, 400, 50, 1);
    send_req(MODE_ADD, 250, 50, 1);
    send_req(MODE_ADD, 150, 100, 0);
    send_req(MODE_ADD, 320, 10, 0);
    send_req(MODE_ADD, 1000, 40, 0);
    send_req(MODE_PAGES, 0, 0, 0);
    send_req(MODE_PAGES, 0, 20, 1);
    send_req(MODE_ACQ, 120, 0, 1);
    send_req(MODE_ACQ, 5, 0, 0);
    send_req(MODE_AT, 500, 0, 0);
    send_req(MODE_AT, 1010, 10, 0);
    send_req(MODE_AT, 1000, 5, 1);
    send_req(MODE_AT, 1035, 5, 0);
    send_req(MODE_AT, 1005, 5, 0);
    send_req(MODE_AT, 5000, 5, 0);
    send_req(MODE_PAGES, 0, 40'hFF_FFFF_FFFF, 0);
    send_req(MODE_PAGES, 0, 5, 0);
    send_req(MODE_ACQ, 40'hFF_FFFF_FFFA, 0, 1);

    write_limit('0);
    random_phase(100);
    write_limit(40'hFF_FFFF_FFFF);
    random_phase(80);
    write_limit(40'($urandom_range(0, 3000)));
    for (int i = 0; i < 70; i++)
      send_req(MODE_ADD, 40'(8 * i + 20000), 40'($urandom_range(1, 4)),
               1'($urandom_range(0, 1)));
    send_req(MODE_AT, 20001, 1, 0);
    drain();
    random_phase(100);
    write_limit(256);
    random_phase(100);
    drain();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
